// File: rtl/core/rcdc_pkg.sv
`timescale 1ns / 1ps

package rcdc_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_COEF_BITS = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int PIX_MAX       = 255;
  localparam int MAX_HEIGHT    = 2048;
  localparam int KSIZE         = 3;

  localparam logic [2:0] CFG_KERNEL_TOP = 3'd0;
  localparam logic [2:0] CFG_KERNEL_MID = 3'd1;
  localparam logic [2:0] CFG_KERNEL_BOT = 3'd2;
  localparam logic [2:0] CFG_DIVISOR    = 3'd3;
  localparam logic [2:0] CFG_WIDTH      = 3'd4;
  localparam logic [2:0] CFG_HEIGHT     = 3'd5;

  // One window column holds three packed pixels, top row in the low bits.
  typedef struct packed {
    logic [2:0][71:0] win;
    logic [10:0]      row;
    logic [10:0]      col;
    logic             last;
  } win_item_t;

  typedef struct packed {
    logic [23:0] row_top;
    logic [23:0] row_mid;
    logic [23:0] row_bot;
    logic [7:0]  divisor;
  } kern_cfg_t;

endpackage

// File: rtl/core/rgb_conv3x3_divide_clamp.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Payload
// input     in         push / full                    in_red_in, in_green_in, in_blue_in,
//                                                     in_frame_start
// result    out        empty / pop                    out_red_out, out_green_out, out_blue_out,
//                                                     out_center_row, out_center_col,
//                                                     out_frame_last
// config    in         cfg_we, cfg_index, cfg_data    write only
//
// In the front end each pixel gets a line store read, then a window shift and store
// write, then, if it yields a result, a push that waits while the queue is full. Interior
// pixels then take nine multiply-accumulate taps and COEF_BITS + 11 restoring division
// steps in the back end, so that shared unit sets the sustained rate for interior pixels.
// Reset is synchronous and clears counters, queue and handshake state; line stores are
// not cleared. A two-entry queue lets the front end keep taking pixels while the back end
// works or the result register waits to be popped.

module rgb_conv3x3_divide_clamp
  import rcdc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic        in_frame_start,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [10:0] out_center_row,
  output logic [10:0] out_center_col,
  output logic        out_frame_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [23:0] ktop_r, kmid_r, kbot_r;
  logic [7:0]  div_r;
  logic [11:0] width_r, height_r;
  kern_cfg_t   kcfg;
  logic        fq_push, fq_full, bq_pop, bq_empty;
  win_item_t   fq_item, bq_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r   <= '0;
      kmid_r   <= '0;
      kbot_r   <= '0;
      div_r    <= 8'd1;
      width_r  <= 12'd3;
      height_r <= 12'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_TOP: ktop_r   <= cfg_data;
        CFG_KERNEL_MID: kmid_r   <= cfg_data;
        CFG_KERNEL_BOT: kbot_r   <= cfg_data;
        CFG_DIVISOR:    div_r    <= cfg_data[7:0];
        CFG_WIDTH:      width_r  <= cfg_data[11:0];
        CFG_HEIGHT:     height_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign kcfg = '{row_top: ktop_r, row_mid: kmid_r, row_bot: kbot_r, divisor: div_r};

  rcdc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .red_in       (in_red_in),
    .green_in     (in_green_in),
    .blue_in      (in_blue_in),
    .frame_start  (in_frame_start),
    .image_width  (width_r),
    .image_height (height_r),
    .q_push       (fq_push),
    .q_item       (fq_item),
    .q_full       (fq_full)
  );

  rcdc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_item (fq_item),
    .q_full  (fq_full),
    .rd_en   (bq_pop),
    .rd_item (bq_item),
    .q_empty (bq_empty)
  );

  rcdc_back #(.COEF_BITS(COEF_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .kcfg       (kcfg),
    .q_empty    (bq_empty),
    .q_item     (bq_item),
    .q_pop      (bq_pop),
    .empty      (empty),
    .pop        (pop),
    .red_out    (out_red_out),
    .green_out  (out_green_out),
    .blue_out   (out_blue_out),
    .center_row (out_center_row),
    .center_col (out_center_col),
    .frame_last (out_frame_last)
  );

endmodule

// File: rtl/core/rcdc_front.sv
`timescale 1ns / 1ps

module rcdc_front
  import rcdc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        frame_start,
  input  logic [11:0] image_width,
  input  logic [11:0] image_height,
  output logic        q_push,
  output win_item_t   q_item,
  input  logic        q_full
);

  localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  typedef enum logic [1:0] {F_IDLE, F_WORK, F_PUSH} fstate_t;

  fstate_t      state_r;
  logic [AW-1:0] col_r, c_r;
  logic [10:0]  row_r, r_r;
  logic [23:0]  px_r, rd_up_r, rd_lo_r;
  logic [2:0][71:0] win_r;
  logic [10:0]  crow_r, ccol_r;
  logic         last_r;

  logic [23:0]  mem_up [MAX_WIDTH];
  logic [23:0]  mem_lo [MAX_WIDTH];

  logic [WW-1:0] w_eff;
  logic [11:0]   h_eff;
  logic [AW-1:0] c_sel;
  logic [10:0]   r_sel;
  logic [WW:0]   c_inc;
  logic [12:0]   r_inc;
  logic          interior;
  logic [AW-1:0] c_m1;

  always_comb begin
    if (image_width < 12'd3) begin
      w_eff = WW'(3);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height < 12'd3) begin
      h_eff = 12'd3;
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = 12'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  assign c_sel    = frame_start ? '0 : col_r;
  assign r_sel    = frame_start ? '0 : row_r;
  assign c_inc    = (WW + 1)'(c_r) + 1'b1;
  assign r_inc    = 13'(r_r) + 13'd1;
  assign c_m1     = c_r - 1'b1;
  assign interior = (r_r >= 11'd2) && (c_r >= AW'(2)) && (12'(r_r) <= h_eff - 12'd1)
                    && (WW'(c_r) <= w_eff - 1'b1);

  assign full   = (state_r != F_IDLE);
  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_item = '{win: win_r, row: crow_r, col: ccol_r, last: last_r};

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && push) begin
      rd_up_r <= mem_up[c_sel];
      rd_lo_r <= mem_lo[c_sel];
    end
    if (state_r == F_WORK) begin
      mem_up[c_r] <= rd_lo_r;
      mem_lo[c_r] <= px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (push) begin
            px_r    <= {blue_in, green_in, red_in};
            c_r     <= c_sel;
            r_r     <= r_sel;
            state_r <= F_WORK;
          end
        end
        F_WORK: begin
          win_r[0] <= win_r[1];
          win_r[1] <= win_r[2];
          win_r[2] <= {px_r, rd_lo_r, rd_up_r};
          crow_r   <= r_r - 11'd1;
          ccol_r   <= 11'(c_m1);
          last_r   <= (12'(r_r) == h_eff - 12'd1) && (WW'(c_r) == w_eff - 1'b1);
          if (c_inc >= (WW + 1)'(w_eff)) begin
            col_r <= '0;
            row_r <= (r_inc >= 13'(h_eff)) ? 11'd0 : 11'(r_inc);
          end else begin
            col_r <= AW'(c_inc);
            row_r <= r_r;
          end
          state_r <= interior ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/rcdc_queue.sv
`timescale 1ns / 1ps

module rcdc_queue
  import rcdc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  win_item_t wr_item,
  output logic      q_full,
  input  logic      rd_en,
  output win_item_t rd_item,
  output logic      q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  win_item_t     slot_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign q_full  = (count_r == CW'(DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_item = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (32'(wptr_r) == DEPTH - 1) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (32'(rptr_r) == DEPTH - 1) ? '0 : rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/rcdc_back.sv
`timescale 1ns / 1ps

module rcdc_back
  import rcdc_pkg::*;
#(
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  kern_cfg_t   kcfg,
  input  logic        q_empty,
  input  win_item_t   q_item,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [10:0] center_row,
  output logic [10:0] center_col,
  output logic        frame_last
);

  localparam int SW   = COEF_BITS + 12;
  localparam int QW   = COEF_BITS + 11;
  localparam int NW   = $clog2(QW + 1);
  localparam int KEXT = (3 * COEF_BITS > 24) ? 3 * COEF_BITS : 24;
  localparam int PW   = COEF_BITS + 9;

  typedef enum logic [2:0] {B_IDLE, B_MAC, B_LOAD, B_DIV, B_OUT} bstate_t;

  bstate_t          state_r;
  win_item_t        item_r;
  logic [1:0]       ti_r, tj_r;
  logic signed [SW-1:0] acc_r [3];
  logic [QW-1:0]    quo_r [3];
  logic [7:0]       rem_r [3];
  logic [2:0]       neg_r;
  logic [NW-1:0]    cnt_r;
  logic             out_valid_r;
  logic [7:0]       res_r [3];
  logic [10:0]      crow_r, ccol_r;
  logic             last_r;

  logic [KEXT-1:0]  krow;
  logic signed [COEF_BITS-1:0] coef;
  logic signed [PW-1:0] prod [3];
  logic [7:0]       dv;
  logic [8:0]       rem_sh [3];
  logic [2:0]       ge;
  logic [7:0]       clamp [3];

  always_comb begin
    case (tj_r)
      2'd0:    krow = KEXT'(kcfg.row_top);
      2'd1:    krow = KEXT'(kcfg.row_mid);
      default: krow = KEXT'(kcfg.row_bot);
    endcase
    coef = krow[ti_r * COEF_BITS +: COEF_BITS];
    for (int p = 0; p < 3; p++) begin
      prod[p] = $signed({1'b0, item_r.win[ti_r][tj_r * 24 + p * 8 +: 8]}) * coef;
    end
  end

  assign dv = (kcfg.divisor == 8'd0) ? 8'd1 : kcfg.divisor;

  // One restoring division step per cycle for each plane, and the clamp of each quotient to 0..255.
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      rem_sh[p] = {rem_r[p], quo_r[p][QW-1]};
      ge[p]     = (rem_sh[p] >= {1'b0, dv});
      if (neg_r[p]) begin
        clamp[p] = 8'd0;
      end else if (quo_r[p] > QW'(PIX_MAX)) begin
        clamp[p] = 8'(PIX_MAX);
      end else begin
        clamp[p] = quo_r[p][7:0];
      end
    end
  end

  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign empty      = !out_valid_r;
  assign red_out    = res_r[0];
  assign green_out  = res_r[1];
  assign blue_out   = res_r[2];
  assign center_row = crow_r;
  assign center_col = ccol_r;
  assign frame_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_OUT && (!out_valid_r || pop)) begin
        out_valid_r <= 1'b1;
      end else if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            item_r  <= q_item;
            ti_r    <= 2'd0;
            tj_r    <= 2'd0;
            for (int p = 0; p < 3; p++) begin
              acc_r[p] <= '0;
            end
            state_r <= B_MAC;
          end
        end
        B_MAC: begin
          for (int p = 0; p < 3; p++) begin
            acc_r[p] <= acc_r[p] + SW'(prod[p]);
          end
          if (ti_r == 2'd2) begin
            ti_r <= 2'd0;
            tj_r <= tj_r + 2'd1;
            if (tj_r == 2'd2) begin
              state_r <= B_LOAD;
            end
          end else begin
            ti_r <= ti_r + 2'd1;
          end
        end
        B_LOAD: begin
          // A negative sum divides to zero or below and so clamps to zero.
          for (int p = 0; p < 3; p++) begin
            neg_r[p] <= acc_r[p][SW-1];
            quo_r[p] <= acc_r[p][QW-1:0];
            rem_r[p] <= 8'd0;
          end
          cnt_r   <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          for (int p = 0; p < 3; p++) begin
            rem_r[p] <= ge[p] ? 8'(rem_sh[p] - {1'b0, dv}) : rem_sh[p][7:0];
            quo_r[p] <= {quo_r[p][QW-2:0], ge[p]};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == NW'(QW - 1)) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid_r || pop) begin
            for (int p = 0; p < 3; p++) begin
              res_r[p] <= clamp[p];
            end
            crow_r  <= item_r.row;
            ccol_r  <= item_r.col;
            last_r  <= item_r.last;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
